[sv/scs_pkg.sv]
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the scanline sprite selector: the entry
// layout, the sorted list control word and the sequencer states.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int SCS_ENTRY_COUNT = 40;
    localparam int SCS_LINE_LIMIT  = 10;

    localparam logic [8:0] LINE_OFFSET  = 9'd16;
    localparam logic [8:0] HEIGHT_SHORT = 9'd8;
    localparam logic [8:0] HEIGHT_TALL  = 9'd16;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SCAN  = 1'b1;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] tile;
        logic [7:0] attr;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pop;
    } t_list_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

[sv/scs_ram.sv]
// ----------------------------------------------------------------------------
// scs_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/scs_sort_list.sv]
// ----------------------------------------------------------------------------
// scs_sort_list
// Row of entry cells kept sorted by ascending x. A new entry goes in after
// every held entry with x not above its own; the head is shifted out.
// ----------------------------------------------------------------------------
module scs_sort_list
    import scs_pkg::*;
#(
    parameter int LIMIT = SCS_LINE_LIMIT,
    parameter int CNT_W = $clog2(LIMIT + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_list_ctl        i_ctl,
    input  t_entry           i_entry,
    output t_entry           o_head,
    output logic [CNT_W-1:0] o_count
);

    t_entry           r_cell [LIMIT];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [LIMIT-1:0] w_gt;
    logic             w_ins_ok;

    assign w_ins_ok = i_ctl.insert && (r_count < CNT_W'(LIMIT));

    // cells holding an entry with larger x move back one place
    always_comb begin
        for (int i = 0; i < LIMIT; i++) begin
            w_gt[i] = (CNT_W'(i) < r_count) && (r_cell[i].x > i_entry.x);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (w_ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop && r_count != '0) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LIMIT; i++) begin
            if (w_ins_ok) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    r_cell[i] <= r_cell[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || CNT_W'(i) == r_count) begin
                    r_cell[i] <= i_entry;
                end
            end else if (i_ctl.pop && !i_ctl.clear) begin
                if (i < LIMIT - 1) begin
                    r_cell[i] <= r_cell[(i < LIMIT - 1) ? i + 1 : i];
                end
            end
        end
    end

    assign o_head  = r_cell[0];
    assign o_count = r_count;

endmodule

[sv/scanline_sprite_selector.sv]
// ----------------------------------------------------------------------------
// scanline_sprite_selector
// Sprite attribute store with per-line selection: walks the store, keeps up
// to PER_LINE_LIMIT covering sprites and emits them sorted by ascending x.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             word
//  command   in         start / busy          mode, oam_address, write_data,
//                                             scan_line
//  result    out        o_strobe (no stall)   found, sprite_y, sprite_x,
//                                             tile_number, attribute_bits, last
//  config    in         i_cfg_valid/o_cfg_ready  tall_sprites
//
//  a write leaves busy low
//  a scan holds busy through the scan and emit states:
//  one entry read per cycle from the four byte-lane RAMs, then one result
//  per cycle from the sorted list
//  after reset the store reads as zero at once (per-byte valid flops)
// ----------------------------------------------------------------------------
module scanline_sprite_selector
    import scs_pkg::*;
#(
    parameter int ENTRY_COUNT    = SCS_ENTRY_COUNT,
    parameter int PER_LINE_LIMIT = SCS_LINE_LIMIT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_mode,
    input  logic [7:0] i_oam_address,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_scan_line,
    output logic       o_strobe,
    output logic       o_found,
    output logic [7:0] o_sprite_y,
    output logic [7:0] o_sprite_x,
    output logic [7:0] o_tile_number,
    output logic [7:0] o_attribute_bits,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    localparam int ENTRY_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CNT_W   = $clog2(PER_LINE_LIMIT + 1);
    localparam int BYTES   = ENTRY_COUNT * 4;

    t_state               r_state;
    t_state               n_state;
    logic                 r_tall;
    logic [7:0]           r_line;
    logic [ENTRY_W-1:0]   r_scan_idx;
    logic                 r_issue_on;
    logic                 r_rd_vld;
    logic                 r_rd_last;
    logic [3:0]           r_rd_bvld;
    logic [BYTES-1:0]     r_byte_vld;

    logic                 r_strobe;
    logic                 r_found;
    logic                 r_last;
    t_entry               r_out;

    logic                 w_accept;
    logic                 w_wr_hit;
    logic [ENTRY_W-1:0]   w_wr_entry;
    logic [7:0]           w_lane_data [4];
    t_entry               w_rd_entry;
    logic [8:0]           w_target;
    logic [8:0]           w_height;
    logic [8:0]           w_y9;
    logic                 w_hit;
    logic                 w_emit;
    t_list_ctl            w_ctl;
    t_entry               w_head;
    logic [CNT_W-1:0]     w_count;

    assign w_accept   = start && !busy;
    assign w_wr_hit   = w_accept && i_mode == MODE_WRITE
                        && ({1'b0, i_oam_address} < 9'(BYTES));
    assign w_wr_entry = ENTRY_W'(i_oam_address[7:2]);

    // one RAM per byte lane so a byte write needs no byte enables
    for (genvar g = 0; g < 4; g++) begin : g_lane
        scs_ram #(
            .WIDTH (8),
            .DEPTH (ENTRY_COUNT)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_wr_hit && i_oam_address[1:0] == 2'(g)),
            .i_waddr (w_wr_entry),
            .i_wdata (i_write_data),
            .i_raddr (r_scan_idx),
            .o_rdata (w_lane_data[g])
        );
    end

    // bytes never written since reset read as zero
    assign w_rd_entry.y    = r_rd_bvld[0] ? w_lane_data[0] : 8'd0;
    assign w_rd_entry.x    = r_rd_bvld[1] ? w_lane_data[1] : 8'd0;
    assign w_rd_entry.tile = r_rd_bvld[2] ? w_lane_data[2] : 8'd0;
    assign w_rd_entry.attr = r_rd_bvld[3] ? w_lane_data[3] : 8'd0;

    assign w_target = {1'b0, r_line} + LINE_OFFSET;
    assign w_height = r_tall ? HEIGHT_TALL : HEIGHT_SHORT;
    assign w_y9     = {1'b0, w_rd_entry.y};
    assign w_hit    = r_rd_vld && w_rd_entry.x != 8'd0
                      && w_y9 <= w_target && (w_y9 + w_height) > w_target;

    scs_sort_list #(
        .LIMIT (PER_LINE_LIMIT),
        .CNT_W (CNT_W)
    ) u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_entry (w_rd_entry),
        .o_head  (w_head),
        .o_count (w_count)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_mode == MODE_SCAN) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && r_rd_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_count <= CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy         = 1'b1;
        w_emit       = 1'b0;
        w_ctl.clear  = 1'b0;
        w_ctl.insert = 1'b0;
        w_ctl.pop    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy        = 1'b0;
                w_ctl.clear = start && i_mode == MODE_SCAN;
            end
            ST_SCAN: begin
                w_ctl.insert = w_hit;
            end
            ST_EMIT: begin
                w_emit    = 1'b1;
                w_ctl.pop = w_count != '0;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tall     <= 1'b0;
            r_issue_on <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_scan_idx <= '0;
            r_byte_vld <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= r_issue_on;
            r_strobe <= w_emit;
            if (i_cfg_valid) begin
                r_tall <= i_cfg_data;
            end
            if (w_wr_hit) begin
                r_byte_vld[{w_wr_entry, i_oam_address[1:0]}] <= 1'b1;
            end
            if (w_ctl.clear) begin
                r_issue_on <= 1'b1;
                r_scan_idx <= '0;
                r_rd_last  <= 1'b0;
            end else if (r_issue_on) begin
                r_rd_last <= r_scan_idx == ENTRY_W'(ENTRY_COUNT - 1);
                if (r_scan_idx == ENTRY_W'(ENTRY_COUNT - 1)) begin
                    r_issue_on <= 1'b0;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.clear) begin
            r_line <= i_scan_line;
        end
        for (int l = 0; l < 4; l++) begin
            r_rd_bvld[l] <= r_byte_vld[{r_scan_idx, 2'(l)}];
        end
        if (w_emit) begin
            r_found <= w_count != '0;
            r_out   <= (w_count != '0) ? w_head : '0;
            r_last  <= w_count <= CNT_W'(1);
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_strobe         = r_strobe;
    assign o_found          = r_found;
    assign o_sprite_y       = r_out.y;
    assign o_sprite_x       = r_out.x;
    assign o_tile_number    = r_out.tile;
    assign o_attribute_bits = r_out.attr;
    assign o_last           = r_last;

`ifndef SYNTH
    a_busy_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && o_last)
        else $error("busy dropped without a final result word");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_found |-> o_last)
        else $error("empty result word not marked last");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("result word right after the final one");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(PER_LINE_LIMIT))
        else $error("selected list overfilled");
`endif

endmodule

[verif/scanline_sprite_selector_test.sv]
// ----------------------------------------------------------------------------
// scanline_sprite_selector_test
// Self-checking bench for the sprite selector: fills the attribute store with
// clusters of sprites, scans lines across them under both sprite heights and
// checks every emitted sprite word against a shadow copy of the store.
// ----------------------------------------------------------------------------
module scanline_sprite_selector_test;
    import scs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES    = SCS_ENTRY_COUNT * 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic       mode;
        logic [7:0] addr;
        logic [7:0] data;
        logic [7:0] line;
    } t_sprite_cmd;

    typedef struct packed {
        logic       found;
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] tile;
        logic [7:0] attr;
        logic       last;
    } t_sprite_hit;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_mode = MODE_WRITE;
    logic [7:0] i_oam_address = 8'd0;
    logic [7:0] i_write_data = 8'd0;
    logic [7:0] i_scan_line = 8'd0;
    logic       o_strobe;
    logic       o_found;
    logic [7:0] o_sprite_y;
    logic [7:0] o_sprite_x;
    logic [7:0] o_tile_number;
    logic [7:0] o_attribute_bits;
    logic       o_last;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data = 1'b0;

    t_sprite_cmd pending_cmds[$];
    t_sprite_hit expected_hits[$];
    logic [7:0]  oam_shadow [STORE_BYTES] = '{default: 8'h00};
    logic        tall_shadow = 1'b0;
    int          idle_pct = 25;
    int          mismatch_count = 0;
    int          stall_cycles = 0;

    scanline_sprite_selector i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_oam_address    (i_oam_address),
        .i_write_data     (i_write_data),
        .i_scan_line      (i_scan_line),
        .o_strobe         (o_strobe),
        .o_found          (o_found),
        .o_sprite_y       (o_sprite_y),
        .o_sprite_x       (o_sprite_x),
        .o_tile_number    (o_tile_number),
        .o_attribute_bits (o_attribute_bits),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // walk the shadow store and queue the sprites expected for one line
    function automatic void select_line_sprites(input logic [7:0] line);
        t_entry      held [SCS_LINE_LIMIT];
        t_entry      ent;
        t_sprite_hit hit;
        int          count;
        int          pos;
        int          target;
        int          height;
        count  = 0;
        target = int'(line) + int'(LINE_OFFSET);
        height = tall_shadow ? int'(HEIGHT_TALL) : int'(HEIGHT_SHORT);
        for (int e = 0; e < SCS_ENTRY_COUNT; e++) begin
            ent = {oam_shadow[4*e], oam_shadow[4*e+1], oam_shadow[4*e+2], oam_shadow[4*e+3]};
            if (ent.x == 8'd0) continue;
            if (count >= SCS_LINE_LIMIT) break;
            if (int'(ent.y) <= target && int'(ent.y) + height > target) begin
                // stable insert: goes after every held sprite with x not above it
                pos = count;
                while (pos > 0 && held[pos-1].x > ent.x) begin
                    held[pos] = held[pos-1];
                    pos--;
                end
                held[pos] = ent;
                count++;
            end
        end
        if (count == 0) begin
            hit = '{found: 1'b0, y: 8'd0, x: 8'd0, tile: 8'd0, attr: 8'd0, last: 1'b1};
            expected_hits = {expected_hits, hit};
        end else begin
            for (int k = 0; k < count; k++) begin
                hit.found = 1'b1;
                hit.y     = held[k].y;
                hit.x     = held[k].x;
                hit.tile  = held[k].tile;
                hit.attr  = held[k].attr;
                hit.last  = (k == count - 1);
                expected_hits = {expected_hits, hit};
            end
        end
    endfunction

    function automatic void apply_cmd(input t_sprite_cmd cmd);
        if (cmd.mode == MODE_WRITE) begin
            if (int'(cmd.addr) < STORE_BYTES) oam_shadow[cmd.addr] = cmd.data;
        end else begin
            select_line_sprites(cmd.line);
        end
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_cmd(pending_cmds[0]);
                void'(pending_cmds.pop_front());
            end
            // a word not yet taken stays on the ports
            if (!(start && busy)) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    start         <= 1'b1;
                    i_mode        <= pending_cmds[0].mode;
                    i_oam_address <= pending_cmds[0].addr;
                    i_write_data  <= pending_cmds[0].data;
                    i_scan_line   <= pending_cmds[0].line;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_sprite_hit got;
        t_sprite_hit want;
        if (i_rst_n) begin
            if (o_strobe) begin
                got = '{found: o_found, y: o_sprite_y, x: o_sprite_x, tile: o_tile_number,
                        attr: o_attribute_bits, last: o_last};
                if (expected_hits.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected sprite word", $time);
                        $display("  got found=%0d y=%02h x=%02h tile=%02h attr=%02h last=%0d",
                                 got.found, got.y, got.x, got.tile, got.attr, got.last);
                    end
                end else begin
                    want = expected_hits.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: sprite word mismatch", $time);
                            $display("  exp found=%0d y=%02h x=%02h tile=%02h attr=%02h last=%0d",
                                     want.found, want.y, want.x, want.tile, want.attr, want.last);
                            $display("  got found=%0d y=%02h x=%02h tile=%02h attr=%02h last=%0d",
                                     got.found, got.y, got.x, got.tile, got.attr, got.last);
                        end
                    end
                end
            end
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic queue_write(input int addr, input int data);
        t_sprite_cmd cmd;
        cmd.mode = MODE_WRITE;
        cmd.addr = addr[7:0];
        cmd.data = data[7:0];
        cmd.line = 8'($urandom_range(0, 255));
        pending_cmds = {pending_cmds, cmd};
    endtask

    task automatic queue_scan(input int line);
        t_sprite_cmd cmd;
        cmd.mode = MODE_SCAN;
        cmd.addr = 8'($urandom_range(0, 255));
        cmd.data = 8'($urandom_range(0, 255));
        cmd.line = line[7:0];
        pending_cmds = {pending_cmds, cmd};
    endtask

    // sender pauses until the block is idle and every word has come back
    task automatic wait_until_drained();
        while (pending_cmds.size() != 0 || start || expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tall_sprites(input logic tall);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= tall;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tall_shadow = tall;
    endtask

    // mostly clusters of sprites around one band followed by scans through it
    task automatic queue_random_traffic(input int count);
        int queued;
        int base;
        int ent;
        int yy;
        int xx;
        int line;
        int pick;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(0, 99) < 70) begin
                base = $urandom_range(0, 175);
                repeat ($urandom_range(3, 12)) begin
                    ent = $urandom_range(0, SCS_ENTRY_COUNT - 1);
                    yy  = base + $urandom_range(0, 20);
                    if (yy > 255) yy = 255;
                    pick = $urandom_range(0, 99);
                    if (pick < 10)      xx = 0;
                    else if (pick < 35) xx = 8 * $urandom_range(1, 3);
                    else                xx = $urandom_range(1, 255);
                    queue_write(4*ent,     yy);
                    queue_write(4*ent + 1, xx);
                    queue_write(4*ent + 2, $urandom_range(0, 255));
                    queue_write(4*ent + 3, $urandom_range(0, 255));
                    queued += 4;
                end
                repeat ($urandom_range(1, 4)) begin
                    line = base + $urandom_range(0, 28) - 16;
                    if (line < 0) line = 0;
                    queue_scan(line);
                    queued++;
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50)      queue_write($urandom_range(0, 255), $urandom_range(0, 255));
                else if (pick < 90) queue_scan($urandom_range(0, 153));
                else                queue_scan($urandom_range(154, 255));
                queued++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_tall_sprites(1'b0);
        idle_pct = 25;
        queue_write(0, 16);
        queue_write(1, 8);
        queue_write(2, 255);
        queue_write(3, 0);
        queue_write(4, 16);            // x stays zero, never selected
        queue_write(8, 16);
        queue_write(9, 8);             // same x as entry 0
        queue_write(10, 8'h5A);
        queue_write(12, 16);
        queue_write(13, 3);
        queue_write(156, 255);
        queue_write(157, 255);
        queue_write(159, 255);
        queue_write(160, 99);          // past the store, dropped
        queue_write(255, 1);
        queue_scan(0);
        queue_scan(7);
        queue_scan(8);
        queue_scan(100);
        queue_scan(239);
        queue_scan(240);
        queue_scan(153);
        queue_scan(255);
        wait_until_drained();

        write_tall_sprites(1'b1);
        queue_scan(8);
        queue_scan(15);
        queue_scan(16);
        queue_random_traffic(130);
        wait_until_drained();

        idle_pct = 77;
        write_tall_sprites(1'b0);
        queue_random_traffic(130);
        wait_until_drained();

        idle_pct = 0;
        write_tall_sprites(1'b1);
        queue_random_traffic(120);
        wait_until_drained();

        repeat (60) @(posedge i_clk);
        if (expected_hits.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
